// ===== sv/assert_macros.svh =====
// Assertion macros shared by the tint blend RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and silenced while rst_n is low.
`define RTBL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and silenced while rst_n is low.
`define RTBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rtbl_pkg.sv =====
// Package with shared types and constants of the row tint blender.
package rtbl_pkg;

    // Geometry default and pixel channel width.
    localparam int DIM_BITS_DEFAULT = 12;
    localparam int CHAN_W           = 8;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

    // Register port geometry.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int CFG_DIM_W    = 13;
    localparam int CFG_WEIGHT_W = 9;

    // Register reset values.
    localparam logic [CFG_DIM_W-1:0]    FRAME_DIM_RESET = 13'd1;
    localparam logic [CFG_WEIGHT_W-1:0] WEIGHT_RESET    = 9'd77;
    localparam logic [CFG_WEIGHT_W-1:0] WEIGHT_FULL     = 9'd256;
    localparam logic [3*CHAN_W-1:0]     ROW_COLOUR_RESET = 24'hFF0000;

    // Register map, indexed by word address.
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BLEND_WEIGHT = 2'd2
    } reg_idx_t;

endpackage

// ===== sv/rtbl_pix_in_if.sv =====
// Handshake channel carrying one incoming RGB pixel word.
interface rtbl_pix_in_if;
    import rtbl_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

// ===== sv/rtbl_pix_out_if.sv =====
// Handshake channel carrying one blended RGB pixel word and its frame flag.
interface rtbl_pix_out_if;
    import rtbl_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_end, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_end, output ready);
endinterface

// ===== sv/rtbl_div.sv =====
// Bit-serial restoring divider shared by all row colour divisions.
`include "assert_macros.svh"

module rtbl_div #(
    parameter int DIM_BITS = rtbl_pkg::DIM_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIM_BITS+8:0] dividend,
    input  logic [DIM_BITS:0]   divisor,
    output logic                done,
    output logic [DIM_BITS+8:0] quotient,
    output logic [DIM_BITS:0]   remainder
);
    localparam int DW    = DIM_BITS + 9;
    localparam int RW    = DIM_BITS + 1;
    localparam int CNT_W = $clog2(DW);

    logic [DW-1:0]    quo_reg;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    divisor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [RW:0]      trial;
    logic [RW:0]      diff;
    logic             fits;
    logic [RW-1:0]    rem_step;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DW-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = trial >= {1'b0, divisor_reg};
        rem_step = fits ? diff[RW-1:0] : trial[RW-1:0];
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Working registers of the division.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // A new division is only ever started once the previous one has finished.
    `RTBL_ASSERT_NOW(a_div_no_restart, start, !busy_reg, "divider restarted while busy")

endmodule

// ===== sv/rtbl_blend.sv =====
// Single-channel alpha blend of a pixel byte with a tint byte.
module rtbl_blend (
    input  logic [rtbl_pkg::CHAN_W-1:0]       pix,
    input  logic [rtbl_pkg::CHAN_W-1:0]       tint,
    input  logic [rtbl_pkg::CFG_WEIGHT_W-1:0] weight,
    output logic [rtbl_pkg::CHAN_W-1:0]       blended
);
    import rtbl_pkg::*;

    localparam int PW = CHAN_W + CFG_WEIGHT_W;

    logic [CFG_WEIGHT_W-1:0] keep;
    logic [PW-1:0]           prod_pix;
    logic [PW-1:0]           prod_tint;
    logic [PW-1:0]           sum;

    // Weighted sum, then drop the eight fraction bits.
    always_comb
    begin
        keep      = WEIGHT_FULL - weight;
        prod_pix  = PW'(pix) * PW'(keep);
        prod_tint = PW'(tint) * PW'(weight);
        sum       = prod_pix + prod_tint;
        blended   = sum[2*CHAN_W-1:CHAN_W];
    end

endmodule

// ===== sv/rainbow_row_tint_blend.sv =====
// Top level of the raster row tint blender with its register port and sequencer.
//
//   Channel   Dir  Handshake           Word
//   pix_in    in   valid/ready         in_red, in_green, in_blue
//   pix_out   out  valid/ready         out_red, out_green, out_blue, frame_end
//   apb       in   psel/penable/pwrite frame_width, frame_height, blend_weight
//
// A pixel that opens a row first goes through the row colour divisions, then is blended.
// Every other pixel goes through accept, one blend step per channel and a write.
// The row colour comes from the bit-serial divider, run three times per row.
// Reset gives width 1, height 1, weight 77, counters at zero and a pure red colour.
// The output register lets the next pixel in while a blended word is still stalled.
`include "assert_macros.svh"

module rainbow_row_tint_blend #(
    parameter int DIM_BITS = rtbl_pkg::DIM_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rtbl_pix_in_if.sink                  pix_in,
    rtbl_pix_out_if.source               pix_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rtbl_pkg::PADDR_W-1:0] paddr,
    input  logic [rtbl_pkg::PDATA_W-1:0] pwdata,
    output logic [rtbl_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import rtbl_pkg::*;

    localparam int DW = DIM_BITS + 9;
    localparam int RW = DIM_BITS + 1;
    localparam int XW = (CFG_DIM_W > RW) ? CFG_DIM_W : RW;
    localparam logic [XW-1:0] DIM_MAX = XW'(1) << DIM_BITS;

    // Channel order inside the pixel buffers.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Hue wheel segments.
    localparam logic [2:0] SEG_R_TO_Y = 3'd0;
    localparam logic [2:0] SEG_Y_TO_G = 3'd1;
    localparam logic [2:0] SEG_G_TO_C = 3'd2;
    localparam logic [2:0] SEG_C_TO_B = 3'd3;
    localparam logic [2:0] SEG_B_TO_M = 3'd4;
    localparam logic [2:0] SEG_M_TO_R = 3'd5;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DIV_ROW  = 6'b000010,
        S_DIV_SEG  = 6'b000100,
        S_DIV_RAMP = 6'b001000,
        S_BLEND    = 6'b010000,
        S_WRITE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_DIM_W-1:0]    frame_width_reg;
    logic [CFG_DIM_W-1:0]    frame_height_reg;
    logic [CFG_WEIGHT_W-1:0] blend_weight_reg;

    logic [DIM_BITS-1:0]     col_reg;
    logic [DIM_BITS-1:0]     row_reg;
    logic [RW-1:0]           ramp_remainder_reg;
    logic [2:0]              wheel_segment_reg;
    logic [3*CHAN_W-1:0]     row_colour_reg;
    logic [1:0]              chan_reg;
    logic                    frame_end_reg;
    logic [CHAN_W-1:0]       pix_reg [3];
    logic [CHAN_W-1:0]       res_reg [3];

    logic                    out_valid_reg;
    logic [CHAN_W-1:0]       out_red_reg;
    logic [CHAN_W-1:0]       out_green_reg;
    logic [CHAN_W-1:0]       out_blue_reg;
    logic                    out_frame_end_reg;

    logic                    cfg_wr;
    reg_idx_t                cfg_idx;
    logic [XW-1:0]           width_ext;
    logic [XW-1:0]           height_ext;
    logic [RW-1:0]           width_eff;
    logic [RW-1:0]           height_eff;
    logic [CFG_WEIGHT_W-1:0] weight_sat;
    logic                    in_accept;
    logic                    last_col;
    logic                    last_row;
    logic                    out_free;

    logic                    div_start;
    logic [DW-1:0]           div_dividend;
    logic                    div_done;
    logic [DW-1:0]           div_quotient;
    logic [RW-1:0]           div_remainder;
    logic [RW-1:0]           ramp_base;

    logic [CHAN_W-1:0]       ramp;
    logic [CHAN_W-1:0]       tint;
    logic [CHAN_W-1:0]       blend_out;

    // Register port: writes complete in the access phase, reads are direct.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            REG_BLEND_WEIGHT: prdata = PDATA_W'(blend_weight_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_DIM_RESET;
            frame_height_reg <= FRAME_DIM_RESET;
            blend_weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_DIM_W-1:0];
                REG_BLEND_WEIGHT: blend_weight_reg <= pwdata[CFG_WEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective frame size (zero acts as one, oversize clamps) and weight limit.
    always_comb
    begin
        width_ext  = XW'(frame_width_reg);
        height_ext = XW'(frame_height_reg);
        if (width_ext == '0)
            width_eff = RW'(1);
        else if (width_ext > DIM_MAX)
            width_eff = RW'(DIM_MAX);
        else
            width_eff = RW'(width_ext);
        if (height_ext == '0)
            height_eff = RW'(1);
        else if (height_ext > DIM_MAX)
            height_eff = RW'(DIM_MAX);
        else
            height_eff = RW'(height_ext);
        weight_sat = (blend_weight_reg > WEIGHT_FULL) ? WEIGHT_FULL : blend_weight_reg;
    end

    // Handshake and raster position.
    assign in_accept    = pix_in.valid && pix_in.ready;
    assign pix_in.ready = (state_reg == S_IDLE);
    assign out_free     = !out_valid_reg || pix_out.ready;
    assign last_col     = (RW'(col_reg) + RW'(1)) >= width_eff;
    assign last_row     = (RW'(row_reg) + RW'(1)) >= height_eff;

    // Divider feed: row mod height, then six times that over height, then the ramp.
    always_comb
    begin
        ramp_base    = div_quotient[0] ? (height_eff - div_remainder) : div_remainder;
        div_start    = 1'b0;
        div_dividend = DW'(row_reg);
        case (state_reg)
            S_IDLE:
            begin
                div_start    = in_accept && (col_reg == '0);
                div_dividend = DW'(row_reg);
            end
            S_DIV_ROW:
            begin
                div_start    = div_done;
                div_dividend = (DW'(div_remainder) << 2) + (DW'(div_remainder) << 1);
            end
            S_DIV_SEG:
            begin
                div_start    = div_done;
                div_dividend = (DW'(ramp_base) << 8) - DW'(ramp_base);
            end
            default:
            begin
                div_start    = 1'b0;
                div_dividend = DW'(row_reg);
            end
        endcase
    end

    rtbl_div #(
        .DIM_BITS (DIM_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (height_eff),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = (col_reg == '0) ? S_DIV_ROW : S_BLEND;
            end
            S_DIV_ROW:
            begin
                if (div_done)
                    state_next = S_DIV_SEG;
            end
            S_DIV_SEG:
            begin
                if (div_done)
                    state_next = S_DIV_RAMP;
            end
            S_DIV_RAMP:
            begin
                if (div_done)
                    state_next = S_BLEND;
            end
            S_BLEND:
            begin
                if (chan_reg == CH_BLUE)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state: sequencer, raster counters, row colour and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            col_reg            <= '0;
            row_reg            <= '0;
            ramp_remainder_reg <= '0;
            wheel_segment_reg  <= '0;
            row_colour_reg     <= ROW_COLOUR_RESET;
            chan_reg           <= CH_RED;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + DIM_BITS'(1);
                end
                else
                begin
                    col_reg <= col_reg + DIM_BITS'(1);
                end
            end

            if (state_reg == S_DIV_SEG && div_done)
            begin
                wheel_segment_reg  <= div_quotient[2:0];
                ramp_remainder_reg <= div_remainder;
            end

            if (state_reg == S_DIV_RAMP && div_done)
            begin
                case (wheel_segment_reg)
                    SEG_R_TO_Y: row_colour_reg <= {CHAN_FULL, ramp, CHAN_ZERO};
                    SEG_Y_TO_G: row_colour_reg <= {ramp, CHAN_FULL, CHAN_ZERO};
                    SEG_G_TO_C: row_colour_reg <= {CHAN_ZERO, CHAN_FULL, ramp};
                    SEG_C_TO_B: row_colour_reg <= {CHAN_ZERO, ramp, CHAN_FULL};
                    SEG_B_TO_M: row_colour_reg <= {ramp, CHAN_ZERO, CHAN_FULL};
                    SEG_M_TO_R: row_colour_reg <= {CHAN_FULL, CHAN_ZERO, ramp};
                    default:    row_colour_reg <= {CHAN_FULL, CHAN_ZERO, ramp};
                endcase
            end

            if (state_reg == S_BLEND)
                chan_reg <= (chan_reg == CH_BLUE) ? CH_RED : chan_reg + 2'd1;

            if (state_reg == S_WRITE && out_free)
                out_valid_reg <= 1'b1;
            else if (pix_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // The ramp byte is the quotient of the last division, always below 256.
    assign ramp = div_quotient[CHAN_W-1:0];

    // Per-channel blend through one shared unit.
    always_comb
    begin
        case (chan_reg)
            CH_RED:   tint = row_colour_reg[3*CHAN_W-1:2*CHAN_W];
            CH_GREEN: tint = row_colour_reg[2*CHAN_W-1:CHAN_W];
            CH_BLUE:  tint = row_colour_reg[CHAN_W-1:0];
            default:  tint = row_colour_reg[CHAN_W-1:0];
        endcase
    end

    rtbl_blend u_blend (
        .pix     (pix_reg[chan_reg]),
        .tint    (tint),
        .weight  (weight_sat),
        .blended (blend_out)
    );

    // Pixel, result and output word registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pix_reg[CH_RED]   <= pix_in.in_red;
            pix_reg[CH_GREEN] <= pix_in.in_green;
            pix_reg[CH_BLUE]  <= pix_in.in_blue;
            frame_end_reg     <= last_col && last_row;
        end
        if (state_reg == S_BLEND)
            res_reg[chan_reg] <= blend_out;
        if (state_reg == S_WRITE && out_free)
        begin
            out_red_reg       <= res_reg[CH_RED];
            out_green_reg     <= res_reg[CH_GREEN];
            out_blue_reg      <= res_reg[CH_BLUE];
            out_frame_end_reg <= frame_end_reg;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_red   = out_red_reg;
    assign pix_out.out_green = out_green_reg;
    assign pix_out.out_blue  = out_blue_reg;
    assign pix_out.frame_end = out_frame_end_reg;

    // A pixel at the start of a row always goes through the row colour divisions.
    `RTBL_ASSERT_NEXT(a_row_start_divides, in_accept && (col_reg == '0),
        state_reg == S_DIV_ROW, "row start skipped the colour divisions")

    // Divider completions only arrive while the sequencer waits for them.
    `RTBL_ASSERT_NOW(a_div_done_expected, div_done,
        state_reg == S_DIV_ROW || state_reg == S_DIV_SEG || state_reg == S_DIV_RAMP,
        "divider finished outside a division step")

    // Once the last pixel of a frame is written out, the raster counters are at zero.
    `RTBL_ASSERT_NEXT(a_frame_wrap, (state_reg == S_WRITE) && out_free && frame_end_reg,
        (col_reg == '0) && (row_reg == '0), "counters did not wrap at frame end")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the raster row tint blender: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
    import rtbl_pkg::*;

    localparam int DIM_BITS  = DIM_BITS_DEFAULT;
    localparam int DIM_LIMIT = 1 << DIM_BITS;
    localparam int DIM_MASK  = DIM_LIMIT - 1;
    localparam int HUE_SEGS  = 6;
    localparam int PHASES    = 10;
    localparam int PHASE_LEN = 60;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } tint_t;

    // One row of the directed table: a register write or a pixel word.
    typedef struct packed {
        logic                 wr;
        reg_idx_t             idx;
        logic [CFG_DIM_W-1:0] val;
        rgb_t                 pix;
        logic                 known;
        tint_t                want;
    } plan_row_t;

    localparam int PLAN_ROWS = 35;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // Reset settings: width 1, height 1, weight 77, row colour pure red.
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h000000, 1'b1, {8'd76, 8'd0, 8'd0, 1'b1}},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hFFFFFF, 1'b1, {8'd255, 8'd178, 8'd178, 1'b1}},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hAA55AA, 1'b1, {8'd195, 8'd59, 8'd118, 1'b1}},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h55AA55, 1'b1, {8'd136, 8'd118, 8'd59, 1'b1}},
        // No tint at all passes the pixel through.
        '{1'b1, REG_BLEND_WEIGHT, 13'd0, 24'h000000, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h123456, 1'b1, {8'h12, 8'h34, 8'h56, 1'b1}},
        // Full tint gives the row colour itself.
        '{1'b1, REG_BLEND_WEIGHT, 13'd256, 24'h000000, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hABCDEF, 1'b1, {8'hFF, 8'h00, 8'h00, 1'b1}},
        // A weight above 256 saturates to full tint.
        '{1'b1, REG_BLEND_WEIGHT, 13'd511, 24'h000000, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h010203, 1'b1, {8'hFF, 8'h00, 8'h00, 1'b1}},
        // Zero sizes act as one.
        '{1'b1, REG_FRAME_WIDTH, 13'd0, 24'h000000, 1'b0, 25'd0},
        '{1'b1, REG_FRAME_HEIGHT, 13'd0, 24'h000000, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hFEDCBA, 1'b1, {8'hFF, 8'h00, 8'h00, 1'b1}},
        // Six single-pixel rows walk the six wheel segments at full tint.
        '{1'b1, REG_FRAME_HEIGHT, 13'd6, 24'h000000, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h0F0F0F, 1'b1, {8'hFF, 8'h00, 8'h00, 1'b0}},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hF0F0F0, 1'b1, {8'hFF, 8'hFF, 8'h00, 1'b0}},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h3C3C3C, 1'b1, {8'h00, 8'hFF, 8'h00, 1'b0}},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hC3C3C3, 1'b1, {8'h00, 8'hFF, 8'hFF, 1'b0}},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h5A5A5A, 1'b1, {8'h00, 8'h00, 8'hFF, 1'b0}},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hA5A5A5, 1'b1, {8'hFF, 8'h00, 8'hFF, 1'b1}},
        // Oversize frame, clamped to the counter range.
        '{1'b1, REG_FRAME_WIDTH, 13'd8191, 24'h000000, 1'b0, 25'd0},
        '{1'b1, REG_FRAME_HEIGHT, 13'd4096, 24'h000000, 1'b0, 25'd0},
        '{1'b1, REG_BLEND_WEIGHT, 13'd77, 24'h000000, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h00FF00, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hFF00FF, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h808080, 1'b0, 25'd0},
        // Shrinking the width leaves the column past the end, so that word ends its row.
        '{1'b1, REG_FRAME_WIDTH, 13'd3, 24'h000000, 1'b0, 25'd0},
        '{1'b1, REG_FRAME_HEIGHT, 13'd7, 24'h000000, 1'b0, 25'd0},
        '{1'b1, REG_BLEND_WEIGHT, 13'd200, 24'h000000, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h7F7F7F, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h010101, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hFE80FE, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h336699, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'hCC9966, 1'b0, 25'd0},
        '{1'b0, REG_FRAME_WIDTH, 13'd0, 24'h000000, 1'b0, 25'd0}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    rtbl_pix_in_if  pix_in_ch ();
    rtbl_pix_out_if pix_out_ch ();

    rainbow_row_tint_blend u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_ch),
        .pix_out (pix_out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow registers and counters of the tint predictor.
    logic [CFG_DIM_W-1:0]    cfg_width;
    logic [CFG_DIM_W-1:0]    cfg_height;
    logic [CFG_WEIGHT_W-1:0] cfg_weight;
    int unsigned             col_at;
    int unsigned             row_at;
    logic [3*CHAN_W-1:0]     hue_latched;

    tint_t tints_due[$];
    int    mismatches;
    int    send_idle_pct;
    int    recv_idle_pct;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #4000000;
        $display("rainbow_row_tint_blend test failed");
        $finish;
    end

    task automatic tint_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // A size of zero acts as one and anything past the counter range is clamped.
    function automatic int unsigned dim_in_use(input logic [CFG_DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > DIM_LIMIT)
            return DIM_LIMIT;
        return v;
    endfunction

    // Fully saturated hue of a row, split into six wheel segments.
    function automatic logic [3*CHAN_W-1:0] hue_for_row(input int unsigned row,
                                                       input int unsigned h);
        int unsigned scaled;
        int unsigned seg;
        int unsigned rem;
        logic [CHAN_W-1:0] up;
        logic [CHAN_W-1:0] dn;
        scaled = HUE_SEGS * row;
        seg    = (scaled / h) % HUE_SEGS;
        rem    = scaled % h;
        up     = CHAN_W'((rem * 255) / h);
        dn     = CHAN_W'(((h - rem) * 255) / h);
        case (seg)
            0:       return {CHAN_FULL, up, CHAN_ZERO};
            1:       return {dn, CHAN_FULL, CHAN_ZERO};
            2:       return {CHAN_ZERO, CHAN_FULL, up};
            3:       return {CHAN_ZERO, dn, CHAN_FULL};
            4:       return {up, CHAN_ZERO, CHAN_FULL};
            default: return {CHAN_FULL, CHAN_ZERO, dn};
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] p,
                                                  input logic [CHAN_W-1:0] c,
                                                  input int unsigned w);
        int unsigned s;
        s = 32'(p) * (256 - w) + 32'(c) * w;
        return CHAN_W'(s >> 8);
    endfunction

    // Works out the blended word of one pixel and advances the raster counters.
    function automatic tint_t tint_next(input rgb_t px);
        tint_t       t;
        int unsigned wt;
        int unsigned wd;
        int unsigned ht;
        bit          end_col;
        bit          end_row;
        wt = (cfg_weight > WEIGHT_FULL) ? 256 : cfg_weight;
        wd = dim_in_use(cfg_width);
        ht = dim_in_use(cfg_height);
        if (col_at == 0)
            hue_latched = hue_for_row(row_at, ht);
        t.red   = mix_chan(px.red,   hue_latched[23:16], wt);
        t.green = mix_chan(px.green, hue_latched[15:8],  wt);
        t.blue  = mix_chan(px.blue,  hue_latched[7:0],   wt);
        end_col = (col_at + 1 >= wd);
        end_row = (row_at + 1 >= ht);
        t.frame_end = end_col && end_row;
        if (end_col)
        begin
            col_at = 0;
            row_at = end_row ? 0 : ((row_at + 1) & DIM_MASK);
        end
        else
        begin
            col_at = (col_at + 1) & DIM_MASK;
        end
        return t;
    endfunction

    // Offers one pixel word, after a random gap, and holds it until taken.
    task automatic send_pixel(input rgb_t px, input logic known, input tint_t want);
        tint_t predicted;
        int    gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            pix_in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predicted = tint_next(px);
        tints_due.push_back(known ? want : predicted);
        pix_in_ch.valid    <= 1'b1;
        pix_in_ch.in_red   <= px.red;
        pix_in_ch.in_green <= px.green;
        pix_in_ch.in_blue  <= px.blue;
        do
            @(posedge clk);
        while (pix_in_ch.ready !== 1'b1);
    endtask

    // Holds the input back until every blended word has come out.
    task automatic wait_for_tints();
        pix_in_ch.valid <= 1'b0;
        while (tints_due.size() != 0)
            @(posedge clk);
    endtask

    // One register transfer: a setup phase, an access phase held until pready, then an idle phase.
    task automatic apb_xfer(input logic wr, input reg_idx_t idx,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input reg_idx_t idx);
        logic [PDATA_W-1:0] back;
        bit                 ok;
        apb_xfer(1'b0, idx, '0, back);
        case (idx)
            REG_FRAME_WIDTH:  ok = (back[CFG_DIM_W-1:0] === cfg_width);
            REG_FRAME_HEIGHT: ok = (back[CFG_DIM_W-1:0] === cfg_height);
            default:          ok = (back[CFG_WEIGHT_W-1:0] === cfg_weight);
        endcase
        if (!ok)
            tint_mismatch($sformatf("register %s reads 0x%0h", idx.name(), back));
    endtask

    // Register writes only happen once the block has gone idle.
    task automatic set_reg(input reg_idx_t idx, input logic [CFG_DIM_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        wait_for_tints();
        apb_xfer(1'b1, idx, PDATA_W'(value), unused);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = value;
            REG_FRAME_HEIGHT: cfg_height = value;
            default:          cfg_weight = value[CFG_WEIGHT_W-1:0];
        endcase
        check_reg(idx);
    endtask

    // The receiver starts stalled, then stalls at random at the rate of the current section.
    initial
    begin
        pix_out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            pix_out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Each blended word taken is compared with the oldest prediction.
    always @(posedge clk)
    begin : tint_monitor
        tint_t want;
        if (rst_n === 1'b1 && pix_out_ch.valid === 1'b1 && pix_out_ch.ready === 1'b1)
        begin
            if (tints_due.size() == 0)
            begin
                tint_mismatch("blended word with no pixel outstanding");
            end
            else
            begin
                want = tints_due.pop_front();
                if (pix_out_ch.out_red !== want.red)
                    tint_mismatch($sformatf("out_red %0d, expected %0d",
                                            pix_out_ch.out_red, want.red));
                if (pix_out_ch.out_green !== want.green)
                    tint_mismatch($sformatf("out_green %0d, expected %0d",
                                            pix_out_ch.out_green, want.green));
                if (pix_out_ch.out_blue !== want.blue)
                    tint_mismatch($sformatf("out_blue %0d, expected %0d",
                                            pix_out_ch.out_blue, want.blue));
                if (pix_out_ch.frame_end !== want.frame_end)
                    tint_mismatch($sformatf("frame_end %0b, expected %0b",
                                            pix_out_ch.frame_end, want.frame_end));
            end
        end
    end

    // Stimulus: reset, register readback, directed table, then random phases.
    initial
    begin : stimulus
        rgb_t                 px;
        logic [CFG_DIM_W-1:0] wv;
        logic [CFG_DIM_W-1:0] hv;
        logic [CFG_DIM_W-1:0] gv;
        int unsigned          pick;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_in_ch.valid    = 1'b0;
        pix_in_ch.in_red   = '0;
        pix_in_ch.in_green = '0;
        pix_in_ch.in_blue  = '0;
        mismatches         = 0;
        send_idle_pct      = 35;
        recv_idle_pct      = 70;
        cfg_width          = FRAME_DIM_RESET;
        cfg_height         = FRAME_DIM_RESET;
        cfg_weight         = WEIGHT_RESET;
        col_at             = 0;
        row_at             = 0;
        hue_latched        = ROW_COLOUR_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers read back their reset values.
        check_reg(REG_FRAME_WIDTH);
        check_reg(REG_FRAME_HEIGHT);
        check_reg(REG_BLEND_WEIGHT);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].wr)
                set_reg(PLAN[i].idx, PLAN[i].val);
            else
                send_pixel(PLAN[i].pix, PLAN[i].known, PLAN[i].want);
        end

        // Three sections: receiver idles more, sender idles more, then no idling.
        for (int sect = 0; sect < 3; sect++)
        begin
            send_idle_pct = (sect == 0) ? 35 : (sect == 1) ? 70 : 0;
            recv_idle_pct = (sect == 0) ? 70 : (sect == 1) ? 35 : 0;
            for (int ph = 0; ph < PHASES; ph++)
            begin
                // Mostly small frames, now and then the size extremes.
                pick = $urandom_range(0, 9);
                wv = (pick == 0) ? 13'd0 :
                     (pick == 1) ? 13'd4096 :
                     (pick == 2) ? CFG_DIM_W'($urandom_range(4097, 8191)) :
                     (pick < 6)  ? CFG_DIM_W'($urandom_range(1, 4)) :
                                   CFG_DIM_W'($urandom_range(5, 40));
                pick = $urandom_range(0, 9);
                hv = (pick == 0) ? 13'd0 :
                     (pick == 1) ? 13'd4096 :
                     (pick == 2) ? 13'd8191 :
                     (pick < 5)  ? CFG_DIM_W'($urandom_range(1, 3)) :
                     (pick < 8)  ? CFG_DIM_W'($urandom_range(4, 13)) :
                                   CFG_DIM_W'($urandom_range(14, 300));
                pick = $urandom_range(0, 9);
                gv = (pick == 0) ? 13'd0 :
                     (pick == 1) ? 13'd256 :
                     (pick == 2) ? CFG_DIM_W'($urandom_range(257, 511)) :
                                   CFG_DIM_W'($urandom_range(0, 255));
                // Not every register each time, so that counters run on mid-frame.
                if (ph == 0 || $urandom_range(0, 2) != 0)
                    set_reg(REG_FRAME_WIDTH, wv);
                if (ph == 0 || $urandom_range(0, 2) != 0)
                    set_reg(REG_FRAME_HEIGHT, hv);
                if (ph == 0 || $urandom_range(0, 2) != 0)
                    set_reg(REG_BLEND_WEIGHT, gv);
                repeat (PHASE_LEN)
                begin
                    px = 24'($urandom);
                    send_pixel(px, 1'b0, '0);
                end
            end
        end

        wait_for_tints();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("rainbow_row_tint_blend test passed");
        else
            $display("rainbow_row_tint_blend test failed");
        $finish;
    end

endmodule
